[src/rc4_pkg.sv]
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int KEY_MAX    = 256;
    localparam int KEY_CNT_W  = 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_ACC,
        ST_KS_WR_N,
        ST_KS_WR_A,
        ST_PG_RD_I,
        ST_PG_RD_J,
        ST_PG_WR_I,
        ST_PG_FIN,
        ST_PASS
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_KEY_IN,
        OP_DATA_IN,
        OP_PASS_IN,
        OP_FILL,
        OP_KS_RD,
        OP_KS_ACC,
        OP_KS_WR_N,
        OP_KS_WR_A,
        OP_PG_RD_I,
        OP_PG_RD_J,
        OP_PG_WR_I,
        OP_PG_FIN,
        OP_PASS_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic keyed;     // a key schedule has completed
        logic n_last;    // sweep counter at its final entry
        logic out_free;  // output register can take a word this cycle
    } dp_stat_t;

endpackage

[src/rc4_stream_cipher_unit.sv]
// RC4 stream cipher. Key bytes (s_tuser = 0) are written one per word into a
// 256-entry key store; the word with s_tlast set starts the key schedule over
// the bytes gathered since the last schedule (bytes beyond 256 are dropped) and
// resets the generator indices. Each data word (s_tuser = 1) returns one word
// on the m_ side: data XOR keystream, or the data unchanged with m_tuser set
// when no key has been scheduled yet. Key words return nothing.
// The final key byte starts a fill of the permutation table followed by
// 256 schedule steps, each a read, an accumulate and two writes. A keyed
// data byte reads S[i], reads S[j], writes S[i] and then writes S[j] and
// the result, since the single read port of the permutation table serves
// the dependent reads of S[i], S[j] and S[S[i]+S[j]] in turn. One word is in
// work at a time; a finished result waits in the output register while the
// next word is accepted.
module rc4_stream_cipher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key_byte, [15:8] data_byte
    input  logic        s_tuser,   // [0] kind: 0 key byte, 1 data byte
    input  logic        s_tlast,   // key_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tuser    // [0] unkeyed
);
    import rc4_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing: key gather, table fill, key schedule, keystream or pass-through per byte
    rc4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .key_last (s_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    // permutation table, key store, indices and output register
    rc4_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .key_byte  (s_tdata[7:0]),
        .data_byte (s_tdata[15:8]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef ASSERT_OFF
    // a key word never produces an output word
    a_key_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("output word produced by a key word");

    // ciphered words only appear once a key schedule has finished
    a_cipher_keyed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> stat.keyed)
        else $error("ciphered word without a scheduled key");

    // a pass-through result is never loaded over a waiting output word
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.out_free |-> cmd.op != OP_PASS_OUT)
        else $error("output word overwritten");

    // no input is taken during a schedule write or the first keystream read
    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_KS_WR_A || cmd.op == OP_PG_RD_I |-> !s_tready)
        else $error("input accepted while busy");
`endif

endmodule

[src/rc4_dp.sv]
module rc4_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rc4_pkg::dp_cmd_t       cmd,
    output rc4_pkg::dp_stat_t      stat,
    input  logic [7:0]             key_byte,
    input  logic [7:0]             data_byte,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tuser
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] key_mem  [PERM_DEPTH];

    logic [KEY_CNT_W-1:0] key_count_reg, key_count_next;
    logic                 keyed_reg, keyed_next;
    logic [7:0]           i_reg, i_next;
    logic [7:0]           j_reg, j_next;
    logic [7:0]           n_reg, n_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [7:0] acc_reg, kidx_reg, si_reg, sj_reg, data_reg;
    logic       hit_i_reg, hit_j_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;

    logic [7:0] pr_data_reg, kr_data_reg;

    logic       pw_en, pr_en, kw_en, kr_en;
    logic [7:0] pw_addr, pw_data, pr_addr;
    logic [7:0] acc_sum, j_sum, t_sum, keystream;
    logic [KEY_CNT_W-1:0] kidx_inc;
    logic       key_room, out_free;

    assign key_room  = (key_count_reg < KEY_CNT_W'(KEY_MAX));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign acc_sum   = acc_reg + pr_data_reg + kr_data_reg;
    assign j_sum     = j_reg + pr_data_reg;
    assign t_sum     = si_reg + pr_data_reg;
    assign kidx_inc  = {1'b0, kidx_reg} + KEY_CNT_W'(1);
    // after the swap S[i] holds sj and S[j] holds si
    assign keystream = hit_j_reg ? si_reg : (hit_i_reg ? sj_reg : pr_data_reg);

    assign stat = '{keyed: keyed_reg, n_last: (n_reg == 8'hFF), out_free: out_free};

    // memory port selection
    always_comb begin
        pw_en   = 1'b0;
        pw_addr = n_reg;
        pw_data = pr_data_reg;
        pr_en   = 1'b0;
        pr_addr = n_reg;
        kw_en   = 1'b0;
        kr_en   = 1'b0;
        unique case (cmd.op)
            OP_KEY_IN: begin
                kw_en = key_room;
            end
            OP_FILL: begin
                pw_en   = 1'b1;
                pw_data = n_reg;
            end
            OP_KS_RD: begin
                pr_en = 1'b1;
                kr_en = 1'b1;
            end
            OP_KS_ACC: begin
                pr_en   = 1'b1;
                pr_addr = acc_sum;
            end
            OP_KS_WR_N: begin
                pw_en = 1'b1;
            end
            OP_KS_WR_A: begin
                pw_en   = 1'b1;
                pw_addr = acc_reg;
                pw_data = si_reg;
            end
            OP_PG_RD_I: begin
                pr_en   = 1'b1;
                pr_addr = i_reg;
            end
            OP_PG_RD_J: begin
                pr_en   = 1'b1;
                pr_addr = j_sum;
            end
            OP_PG_WR_I: begin
                pw_en   = 1'b1;
                pw_addr = i_reg;
                pr_en   = 1'b1;
                pr_addr = t_sum;
            end
            OP_PG_FIN: begin
                pw_en   = 1'b1;
                pw_addr = j_reg;
                pw_data = si_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pw_en) begin
            perm_mem[pw_addr] <= pw_data;
        end
        if (pr_en) begin
            pr_data_reg <= perm_mem[pr_addr];
        end
        if (kw_en) begin
            key_mem[key_count_reg[7:0]] <= key_byte;
        end
        if (kr_en) begin
            kr_data_reg <= key_mem[kidx_reg];
        end
    end

    // control state
    always_comb begin
        key_count_next = key_count_reg;
        keyed_next     = keyed_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        unique case (cmd.op)
            OP_KEY_IN: begin
                if (key_room) begin
                    key_count_next = key_count_reg + KEY_CNT_W'(1);
                end
            end
            OP_DATA_IN: begin
                i_next = i_reg + 8'd1;
            end
            OP_FILL: begin
                n_next = n_reg + 8'd1;
            end
            OP_KS_WR_A: begin
                n_next = n_reg + 8'd1;
                if (n_reg == 8'hFF) begin
                    keyed_next     = 1'b1;
                    i_next         = '0;
                    j_next         = '0;
                    key_count_next = '0;
                end
            end
            OP_PG_RD_J: begin
                j_next = j_sum;
            end
            OP_PG_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                end
            end
            OP_PASS_OUT: begin
                m_tvalid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= '0;
            keyed_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            key_count_reg <= key_count_next;
            keyed_reg     <= keyed_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_DATA_IN, OP_PASS_IN: begin
                data_reg <= data_byte;
            end
            OP_FILL: begin
                acc_reg  <= '0;
                kidx_reg <= '0;
            end
            OP_KS_ACC: begin
                acc_reg <= acc_sum;
                si_reg  <= pr_data_reg;
            end
            OP_KS_WR_A: begin
                kidx_reg <= (kidx_inc == key_count_reg) ? 8'd0 : kidx_inc[7:0];
            end
            OP_PG_RD_J: begin
                si_reg <= pr_data_reg;
            end
            OP_PG_WR_I: begin
                sj_reg    <= pr_data_reg;
                hit_i_reg <= (t_sum == i_reg);
                hit_j_reg <= (t_sum == j_reg);
            end
            OP_PG_FIN: begin
                if (out_free) begin
                    m_tdata_reg <= data_reg ^ keystream;
                    m_tuser_reg <= 1'b0;
                end
            end
            OP_PASS_OUT: begin
                m_tdata_reg <= data_reg;
                m_tuser_reg <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[src/rc4_ctrl.sv]
module rc4_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               kind,
    input  logic               key_last,
    input  rc4_pkg::dp_stat_t  stat,
    output rc4_pkg::dp_cmd_t   cmd
);
    import rc4_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    priority if (!kind) begin
                        cmd.op = OP_KEY_IN;
                        if (key_last) begin
                            state_next = ST_FILL;
                        end
                    end else if (stat.keyed) begin
                        cmd.op     = OP_DATA_IN;
                        state_next = ST_PG_RD_I;
                    end else begin
                        cmd.op     = OP_PASS_IN;
                        state_next = ST_PASS;
                    end
                end
            end
            ST_FILL: begin
                cmd.op = OP_FILL;
                if (stat.n_last) begin
                    state_next = ST_KS_RD;
                end
            end
            ST_KS_RD: begin
                cmd.op     = OP_KS_RD;
                state_next = ST_KS_ACC;
            end
            ST_KS_ACC: begin
                cmd.op     = OP_KS_ACC;
                state_next = ST_KS_WR_N;
            end
            ST_KS_WR_N: begin
                cmd.op     = OP_KS_WR_N;
                state_next = ST_KS_WR_A;
            end
            ST_KS_WR_A: begin
                cmd.op     = OP_KS_WR_A;
                state_next = stat.n_last ? ST_IDLE : ST_KS_RD;
            end
            ST_PG_RD_I: begin
                cmd.op     = OP_PG_RD_I;
                state_next = ST_PG_RD_J;
            end
            ST_PG_RD_J: begin
                cmd.op     = OP_PG_RD_J;
                state_next = ST_PG_WR_I;
            end
            ST_PG_WR_I: begin
                cmd.op     = OP_PG_WR_I;
                state_next = ST_PG_FIN;
            end
            ST_PG_FIN: begin
                cmd.op = OP_PG_FIN;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PASS: begin
                if (stat.out_free) begin
                    cmd.op     = OP_PASS_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[tb/tb_rc4_stream_cipher_unit.sv]
`timescale 1ns / 1ps

module tb_rc4_stream_cipher_unit;

    import rc4_pkg::*;

    // word kinds carried on tuser
    localparam bit KIND_KEY  = 1'b0;
    localparam bit KIND_DATA = 1'b1;

    localparam int N_WORDS      = 1650;
    localparam int HOLD_CYCLES  = 400;   // long output hold-off
    localparam int DRAIN_CYCLES = 1400;  // covers a full key schedule
    localparam int MAX_PRINTS   = 30;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              unkeyed;
    } cipher_result_t;

    // Keystream predictor plus the queue of bytes it expects back.
    class keystream_scoreboard;
        logic [BYTE_W-1:0]    perm [PERM_DEPTH];
        logic [BYTE_W-1:0]    key_mem [PERM_DEPTH];
        logic [KEY_CNT_W-1:0] key_cnt;
        logic [BYTE_W-1:0]    idx_i;
        logic [BYTE_W-1:0]    idx_j;
        bit                   keyed;
        cipher_result_t       expected_bytes [$];
        int errors;
        int n_schedules;
        int longest_key;
        int n_keyed;
        int n_unkeyed;

        function new();
            key_cnt     = '0;
            idx_i       = '0;
            idx_j       = '0;
            keyed       = 1'b0;
            errors      = 0;
            n_schedules = 0;
            longest_key = 0;
            n_keyed     = 0;
            n_unkeyed   = 0;
        endfunction

        function void swap_perm(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] tmp;
            tmp     = perm[a];
            perm[a] = perm[b];
            perm[b] = tmp;
        endfunction

        function void schedule_key();
            int                len;
            logic [BYTE_W-1:0] acc;
            len = int'(key_cnt);
            acc = '0;
            if (len > longest_key)
                longest_key = len;
            for (int n = 0; n < PERM_DEPTH; n++)
                perm[n] = BYTE_W'(n);
            for (int n = 0; n < PERM_DEPTH; n++) begin
                acc = acc + perm[n] + key_mem[n % len];
                swap_perm(BYTE_W'(n), acc);
            end
            idx_i   = '0;
            idx_j   = '0;
            keyed   = 1'b1;
            key_cnt = '0;
            n_schedules++;
        endfunction

        function void note_word(bit kind, logic [7:0] kb, bit last, logic [7:0] db);
            cipher_result_t    res;
            logic [BYTE_W-1:0] t;
            if (kind == KIND_KEY) begin
                // bytes past KEY_MAX are dropped, but last still schedules
                if (int'(key_cnt) < KEY_MAX) begin
                    key_mem[key_cnt[BYTE_W-1:0]] = kb;
                    key_cnt = key_cnt + 1'b1;
                end
                if (last)
                    schedule_key();
            end else if (!keyed) begin
                res.out_byte = db;
                res.unkeyed  = 1'b1;
                expected_bytes.push_back(res);
            end else begin
                idx_i = idx_i + 1'b1;
                idx_j = idx_j + perm[idx_i];
                swap_perm(idx_i, idx_j);
                t = perm[idx_i] + perm[idx_j];
                res.out_byte = db ^ perm[t];
                res.unkeyed  = 1'b0;
                expected_bytes.push_back(res);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_word(logic [7:0] got_byte, logic got_unkeyed);
            cipher_result_t want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected result %02h/%0b", got_byte, got_unkeyed));
            end else begin
                want = expected_bytes.pop_front();
                if (want.unkeyed) n_unkeyed++;
                else              n_keyed++;
                if (got_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              got_byte, want.out_byte));
                if (got_unkeyed !== want.unkeyed)
                    report_mismatch($sformatf("unkeyed %0b, want %0b",
                                              got_unkeyed, want.unkeyed));
            end
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [7:0] key_byte, [15:8] data_byte
    logic        s_tuser  = 1'b0;  // [0] kind
    logic        s_tlast  = 1'b0;  // key_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tuser;          // [0] unkeyed

    keystream_scoreboard sb;

    int send_idle_pct = 32;
    int recv_idle_pct = 56;
    int words_sent    = 0;
    int hold_req      = 0;   // bumped by the sender to request a hold-off
    int hold_seen     = 0;
    int hold_left     = 0;

    always #5 aclk = ~aclk;

    rc4_stream_cipher_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Monitor: check results first, then log the accepted input word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_word(s_tuser, s_tdata[7:0], s_tlast, s_tdata[15:8]);
        end
    end

    // One word on the input side; returns after the handshake edge.
    task automatic send_word(bit kind, logic [7:0] kb, bit last, logic [7:0] db);
        int gap;
        if ($urandom_range(99, 0) < send_idle_pct) begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            s_tuser  <= 1'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {db, kb};
        s_tuser  <= kind;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        // idle profile: sender-light, then receiver-light, then none
        if (words_sent == N_WORDS / 3) begin
            send_idle_pct <= 56;
            recv_idle_pct <= 32;
        end else if (words_sent == 2 * N_WORDS / 3) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
    endtask

    // Key bytes: key_last only on the final one, unless the sequence is cut.
    task automatic send_key(int len, bit with_last);
        for (int n = 0; n < len; n++)
            send_word(KIND_KEY, 8'($urandom), with_last && (n == len - 1), 8'($urandom));
    endtask

    // Data bytes with random noise in the unused key fields.
    task automatic send_data(int len);
        for (int n = 0; n < len; n++)
            send_word(KIND_DATA, 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    initial begin
        int  seq;
        int  key_len;
        int  head;
        bit  cut;
        bit  pressed;

        sb = new();
        seq     = 0;
        pressed = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // data before any key: passthrough, flagged
        send_word(KIND_DATA, 8'hff, 1'b1, 8'h00);
        send_word(KIND_DATA, 8'h00, 1'b0, 8'hff);
        send_word(KIND_DATA, 8'h5a, 1'b1, 8'ha5);
        // one-byte key of zero
        send_word(KIND_KEY, 8'h00, 1'b1, 8'hff);
        send_word(KIND_DATA, 8'hff, 1'b0, 8'h00);
        send_word(KIND_DATA, 8'h00, 1'b1, 8'hff);
        send_word(KIND_DATA, 8'h80, 1'b0, 8'h01);
        // new key gathered while data still runs on the old keystream
        send_word(KIND_KEY, 8'hff, 1'b0, 8'h00);
        send_word(KIND_KEY, 8'h80, 1'b0, 8'hff);
        send_word(KIND_DATA, 8'h01, 1'b0, 8'h80);
        send_word(KIND_DATA, 8'hfe, 1'b1, 8'h7f);
        send_word(KIND_KEY, 8'h01, 1'b1, 8'h55);
        send_word(KIND_DATA, 8'h00, 1'b0, 8'h00);
        send_word(KIND_DATA, 8'hff, 1'b0, 8'hff);
        send_word(KIND_DATA, 8'h55, 1'b1, 8'haa);
        send_word(KIND_DATA, 8'haa, 1'b0, 8'h55);

        // random key/data sequences
        while (words_sent < N_WORDS) begin
            if (seq == 4)
                key_len = KEY_MAX;               // full-length key
            else if (seq == 12)
                key_len = KEY_MAX + 44;          // last lands on a dropped byte
            else if ($urandom_range(7, 0) == 0)
                key_len = $urandom_range(64, 17);
            else
                key_len = $urandom_range(16, 1);
            cut  = (seq != 4 && seq != 12 && $urandom_range(9, 0) == 0);
            head = ($urandom_range(3, 0) == 0) ? $urandom_range(key_len - 1, 0) : 0;
            if (head != 0) begin
                send_key(head, 1'b0);
                send_data($urandom_range(6, 1));
            end
            send_key(key_len - head, !cut);
            // long receiver stall while the sender keeps offering data;
            // the first data word is taken only once any schedule is done
            if (!pressed && words_sent >= 2 * N_WORDS / 3) begin
                send_data(1);
                hold_req <= hold_req + 1;
                pressed = 1'b1;
            end
            send_data($urandom_range(40, 4));
            seq++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words; checked %0d keyed and %0d unkeyed bytes over %0d schedules,",
                 words_sent, sb.n_keyed, sb.n_unkeyed, sb.n_schedules);
        $display("keys up to %0d bytes, oversize key and a %0d-cycle output stall included.",
                 sb.longest_key, HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TIMEOUT after %0t", $time);
        $display("Verification failed");
        $finish;
    end

endmodule

[rc4_stream_cipher_unit.f]
src/rc4_pkg.sv
src/rc4_dp.sv
src/rc4_ctrl.sv
src/rc4_stream_cipher_unit.sv
tb/tb_rc4_stream_cipher_unit.sv
